// File: hw/rtl/lpbp_pkg.sv
// shared constants, codes and types for the page buffer pool frame table
// no dependencies
`timescale 1ns / 1ps

package lpbp_pkg;

   localparam int FRAMES_DEF     = 16;
   localparam int PIN_BITS_DEF   = 8;
   localparam int TABLE_BITS     = 4;
   localparam int PAGE_BITS      = 32;
   localparam int FRAME_OUT_BITS = 4;

   typedef enum logic {
      OP_GET = 1'b0,
      OP_PUT = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      ST_OK          = 2'd0,
      ST_NO_VICTIM   = 2'd1,
      ST_NOT_RESIDENT = 2'd2
   } status_type;

   typedef struct packed {
      logic [FRAME_OUT_BITS-1:0] frame_index;
      logic                      hit;
      logic                      fetch_needed;
      logic                      writeback_needed;
      status_type                status;
   } result_type;

endpackage

// File: hw/rtl/lpbp_if.sv
// request and response channel interfaces of the page buffer pool
// depends on lpbp_pkg
`timescale 1ns / 1ps

interface lpbp_req_if;
   logic                             valid;
   logic                             ready;
   lpbp_pkg::opcode_type             opcode;
   logic [lpbp_pkg::TABLE_BITS-1:0]  table_number;
   logic [lpbp_pkg::PAGE_BITS-1:0]   page_number;
   logic                             modified;

   modport source (output valid, opcode, table_number, page_number, modified, input ready);
   modport sink (input valid, opcode, table_number, page_number, modified, output ready);
endinterface

interface lpbp_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic [lpbp_pkg::FRAME_OUT_BITS-1:0]  frame_index;
   logic                                 hit;
   logic                                 fetch_needed;
   logic                                 writeback_needed;
   lpbp_pkg::status_type                 status;

   modport source (output valid, frame_index, hit, fetch_needed, writeback_needed, status,
                   input ready);
   modport sink (input valid, frame_index, hit, fetch_needed, writeback_needed, status,
                 output ready);
endinterface

// File: hw/rtl/lpbp_ram.sv
// generic simple dual port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module lpbp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

// File: hw/rtl/lru_page_buffer_pool.sv
// frame table of a page buffer pool: lookup, pin counts, lru victim choice
// depends on lpbp_pkg, lpbp_if and lpbp_ram
//
//   channel  dir  carries
//   req_ch   in   opcode, table_number, page_number, modified
//   rsp_ch   out  frame_index, hit, fetch_needed, writeback_needed, status
//
// each request starts with a tag scan over the frame ram; a get hit or a put miss
// ends there, while a get miss and a put hit then walk the recency ram (the victim
// walk also reads the frame ram per position)
// one request in flight; the next is taken while a response waits for the sink
// reset is synchronous and needs no clearing pass: per-frame and per-position
// valid bits stand for the reset contents

`timescale 1ns / 1ps

module lru_page_buffer_pool #(
   parameter int FRAMES   = lpbp_pkg::FRAMES_DEF,
   parameter int PIN_BITS = lpbp_pkg::PIN_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   lpbp_req_if.sink  req_ch,
   lpbp_rsp_if.source rsp_ch
);

   localparam int IW      = $clog2(FRAMES);
   localparam int CW      = IW + 1;
   localparam int TB      = lpbp_pkg::TABLE_BITS;
   localparam int PB      = lpbp_pkg::PAGE_BITS;
   localparam int EW      = TB + PB + PIN_BITS + 1;
   localparam int PIN_LO  = 1;
   localparam int PG_LO   = PIN_BITS + 1;
   localparam int TBL_LO  = PIN_BITS + PB + 1;
   localparam logic [PIN_BITS-1:0] PIN_MAX = '1;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SCAN,
      S_VWALK,
      S_RWALK,
      S_DONE
   } state_type;

   state_type               state_ff, state_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic                    v1_ff, v1_in, v2_ff, v2_in;
   logic [IW-1:0]           a1_ff, a1_in, a2_ff, a2_in;
   logic                    found_ff, found_in;
   logic [IW-1:0]           fidx_ff, fidx_in;
   logic [EW-1:0]           fdata_ff, fdata_in;
   lpbp_pkg::opcode_type    op_ff, op_in;
   logic [TB-1:0]           tbl_ff, tbl_in;
   logic [PB-1:0]           pg_ff, pg_in;
   logic                    mod_ff, mod_in;
   lpbp_pkg::result_type    res_ff, res_in, rsp_ff, rsp_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FRAMES-1:0]       fvalid_ff, fvalid_in, rvalid_ff, rvalid_in;

   logic                    f_we, r_we;
   logic [IW-1:0]           f_waddr, f_raddr, r_waddr, r_raddr;
   logic [EW-1:0]           f_wdata, f_rdata;
   logic [IW-1:0]           r_wdata, r_rdata;

   logic                    issue;
   logic [IW-1:0]           order;
   logic [PIN_BITS-1:0]     pin, new_pin;
   logic                    new_dirty;

   lpbp_ram #(.WIDTH(EW), .DEPTH(FRAMES)) u_frame_ram (
      .clock (clock), .we (f_we), .waddr (f_waddr), .wdata (f_wdata),
      .re (1'b1), .raddr (f_raddr), .rdata (f_rdata)
   );

   lpbp_ram #(.WIDTH(IW), .DEPTH(FRAMES)) u_recency_ram (
      .clock (clock), .we (r_we), .waddr (r_waddr), .wdata (r_wdata),
      .re (1'b1), .raddr (r_raddr), .rdata (r_rdata)
   );

   assign issue = cnt_ff < CW'(FRAMES);
   assign order = rvalid_ff[a1_ff] ? r_rdata : a1_ff;
   assign pin   = fdata_ff[PIN_LO +: PIN_BITS];

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      v1_in        = 1'b0;
      v2_in        = 1'b0;
      a1_in        = a1_ff;
      a2_in        = a2_ff;
      found_in     = found_ff;
      fidx_in      = fidx_ff;
      fdata_in     = fdata_ff;
      op_in        = op_ff;
      tbl_in       = tbl_ff;
      pg_in        = pg_ff;
      mod_in       = mod_ff;
      res_in       = res_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      fvalid_in    = fvalid_ff;
      rvalid_in    = rvalid_ff;
      f_we         = 1'b0;
      f_waddr      = fidx_ff;
      f_wdata      = fdata_ff;
      f_raddr      = cnt_ff[IW-1:0];
      r_we         = 1'b0;
      r_waddr      = a1_ff;
      r_wdata      = order;
      r_raddr      = cnt_ff[IW-1:0];
      new_pin      = pin;
      new_dirty    = fdata_ff[0];

      case (state_ff)
         S_IDLE: begin
            if (req_ch.valid) begin
               op_in    = req_ch.opcode;
               tbl_in   = req_ch.table_number;
               pg_in    = req_ch.page_number;
               mod_in   = req_ch.modified;
               cnt_in   = '0;
               found_in = 1'b0;
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            v1_in = issue;
            a1_in = cnt_ff[IW-1:0];
            if (v1_ff && fvalid_ff[a1_ff] && !found_ff
                && f_rdata[TBL_LO +: TB] == tbl_ff && f_rdata[PG_LO +: PB] == pg_ff) begin
               found_in = 1'b1;
               fidx_in  = a1_ff;
               fdata_in = f_rdata;
            end
            if (!issue && !v1_ff) begin
               res_in   = '{frame_index: '0, hit: 1'b0, fetch_needed: 1'b0,
                            writeback_needed: 1'b0, status: lpbp_pkg::ST_OK};
               cnt_in   = '0;
               found_in = 1'b0;
               if (op_ff == lpbp_pkg::OP_GET) begin
                  if (found_ff) begin
                     new_pin = (pin == PIN_MAX) ? pin : pin + PIN_BITS'(1);
                     f_we    = 1'b1;
                     f_wdata = {fdata_ff[EW-1:PG_LO], new_pin, new_dirty};
                     res_in.frame_index = lpbp_pkg::FRAME_OUT_BITS'(fidx_ff);
                     res_in.hit         = 1'b1;
                     state_in           = S_DONE;
                  end else begin
                     state_in = S_VWALK;
                  end
               end else begin
                  if (found_ff) begin
                     new_pin   = (pin == '0) ? pin : pin - PIN_BITS'(1);
                     new_dirty = fdata_ff[0] | mod_ff;
                     f_we      = 1'b1;
                     f_wdata   = {fdata_ff[EW-1:PG_LO], new_pin, new_dirty};
                     res_in.frame_index      = lpbp_pkg::FRAME_OUT_BITS'(fidx_ff);
                     res_in.hit              = 1'b1;
                     res_in.writeback_needed = (new_pin == '0) && new_dirty;
                     state_in                = S_RWALK;
                  end else begin
                     res_in.status = lpbp_pkg::ST_NOT_RESIDENT;
                     state_in      = S_DONE;
                  end
               end
            end
         end
         S_VWALK: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            v1_in   = issue;
            a1_in   = cnt_ff[IW-1:0];
            f_raddr = order;
            v2_in   = v1_ff;
            a2_in   = order;
            if (v2_ff && !found_ff
                && (!fvalid_ff[a2_ff] || f_rdata[PIN_LO +: PIN_BITS] == '0)) begin
               found_in = 1'b1;
               fidx_in  = a2_ff;
            end
            if (!issue && !v1_ff && !v2_ff) begin
               if (found_ff) begin
                  f_we                = 1'b1;
                  f_waddr             = fidx_ff;
                  f_wdata             = {tbl_ff, pg_ff, PIN_BITS'(1), 1'b0};
                  fvalid_in[fidx_ff]  = 1'b1;
                  res_in.frame_index  = lpbp_pkg::FRAME_OUT_BITS'(fidx_ff);
                  res_in.fetch_needed = 1'b1;
               end else begin
                  res_in.status = lpbp_pkg::ST_NO_VICTIM;
               end
               state_in = S_DONE;
            end
         end
         S_RWALK: begin
            if (issue) begin
               cnt_in = cnt_ff + CW'(1);
            end
            v1_in = issue;
            a1_in = cnt_ff[IW-1:0];
            if (v1_ff) begin
               if (found_ff) begin
                  r_we                       = 1'b1;
                  r_waddr                    = a1_ff - IW'(1);
                  r_wdata                    = order;
                  rvalid_in[a1_ff - IW'(1)]  = 1'b1;
               end
               if (order == fidx_ff) begin
                  found_in = 1'b1;
               end
            end
            if (!issue && !v1_ff) begin
               r_we                     = 1'b1;
               r_waddr                  = IW'(FRAMES - 1);
               r_wdata                  = fidx_ff;
               rvalid_in[IW'(FRAMES - 1)] = 1'b1;
               state_in                 = S_DONE;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_in       = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         found_ff     <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         fvalid_ff    <= '0;
         rvalid_ff    <= '0;
      end else begin
         state_ff     <= state_in;
         v1_ff        <= v1_in;
         v2_ff        <= v2_in;
         found_ff     <= found_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         fvalid_ff    <= fvalid_in;
         rvalid_ff    <= rvalid_in;
      end
      a1_ff    <= a1_in;
      a2_ff    <= a2_in;
      fidx_ff  <= fidx_in;
      fdata_ff <= fdata_in;
      op_ff    <= op_in;
      tbl_ff   <= tbl_in;
      pg_ff    <= pg_in;
      mod_ff   <= mod_in;
      res_ff   <= res_in;
      rsp_ff   <= rsp_in;
   end

   assign req_ch.ready            = (state_ff == S_IDLE);
   assign rsp_ch.valid            = rsp_valid_ff;
   assign rsp_ch.frame_index      = rsp_ff.frame_index;
   assign rsp_ch.hit              = rsp_ff.hit;
   assign rsp_ch.fetch_needed     = rsp_ff.fetch_needed;
   assign rsp_ch.writeback_needed = rsp_ff.writeback_needed;
   assign rsp_ch.status           = rsp_ff.status;

   // frame and recency rams are never written in the same cycle
   assert property (@(posedge clock) disable iff (reset) !(f_we && r_we))
      else $error("frame and recency writes overlap");

   // error responses carry no frame and no flags
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.status != lpbp_pkg::ST_OK |->
         rsp_ff.frame_index == '0 && !rsp_ff.hit && !rsp_ff.fetch_needed
         && !rsp_ff.writeback_needed)
      else $error("error response with flags set");

   // a fetch is only asked for on a miss
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.fetch_needed |-> !rsp_ff.hit && !rsp_ff.writeback_needed)
      else $error("fetch on a hit");

   // a victim retag always leaves its frame valid
   assert property (@(posedge clock) disable iff (reset)
      state_ff == S_VWALK && f_we |=> fvalid_ff[$past(f_waddr)])
      else $error("retagged frame not valid");

endmodule

// File: tb/lpbp_checker.sv
// checker for the page buffer pool frame table: predicts each response from accepted requests
// depends on lpbp_pkg and lpbp_if
`timescale 1ns / 1ps

module lpbp_checker (
   input  logic        clock,
   input  logic        reset,
   lpbp_req_if         req_ch,
   lpbp_rsp_if         rsp_ch,
   output int          fail_count,
   output int          pending_count
);

   localparam int NF = lpbp_pkg::FRAMES_DEF;
   localparam int PIN_MAX = (1 << lpbp_pkg::PIN_BITS_DEF) - 1;

   logic [lpbp_pkg::TABLE_BITS-1:0] pool_table [NF];
   logic [lpbp_pkg::PAGE_BITS-1:0]  pool_page [NF];
   logic                            pool_valid [NF];
   int                              pool_pins [NF];
   logic                            pool_dirty [NF];
   int                              lru_list [NF];
   lpbp_pkg::result_type            expected_q [$];

   function automatic lpbp_pkg::result_type pool_access(
         lpbp_pkg::opcode_type op, logic [lpbp_pkg::TABLE_BITS-1:0] tbl,
         logic [lpbp_pkg::PAGE_BITS-1:0] pg, logic mod);
      lpbp_pkg::result_type r;
      int f;
      int q;
      r = '0;
      r.status = lpbp_pkg::ST_OK;
      f = -1;
      for (int i = NF - 1; i >= 0; i--)
         if (pool_valid[i] && pool_table[i] == tbl && pool_page[i] == pg) f = i;
      if (op == lpbp_pkg::OP_GET) begin
         if (f >= 0) begin
            if (pool_pins[f] < PIN_MAX) pool_pins[f]++;
            r.frame_index = lpbp_pkg::FRAME_OUT_BITS'(f);
            r.hit = 1'b1;
         end else begin
            for (int p = NF - 1; p >= 0; p--)
               if (pool_pins[lru_list[p]] == 0) f = lru_list[p];
            if (f < 0) r.status = lpbp_pkg::ST_NO_VICTIM;
            else begin
               pool_table[f] = tbl;
               pool_page[f] = pg;
               pool_valid[f] = 1'b1;
               pool_dirty[f] = 1'b0;
               pool_pins[f] = 1;
               r.frame_index = lpbp_pkg::FRAME_OUT_BITS'(f);
               r.fetch_needed = 1'b1;
            end
         end
      end else if (f < 0) begin
         r.status = lpbp_pkg::ST_NOT_RESIDENT;
      end else begin
         if (pool_pins[f] > 0) pool_pins[f]--;
         if (mod) pool_dirty[f] = 1'b1;
         q = 0;
         for (int p = 0; p < NF; p++)
            if (lru_list[p] == f) q = p;
         for (int p = q; p < NF - 1; p++) lru_list[p] = lru_list[p + 1];
         lru_list[NF - 1] = f;
         r.frame_index = lpbp_pkg::FRAME_OUT_BITS'(f);
         r.hit = 1'b1;
         r.writeback_needed = (pool_pins[f] == 0) && pool_dirty[f];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      lpbp_pkg::result_type want;
      if (reset) begin
         for (int i = 0; i < NF; i++) begin
            pool_valid[i] = 1'b0;
            pool_pins[i] = 0;
            pool_dirty[i] = 1'b0;
            lru_list[i] = i;
            pool_table[i] = '0;
            pool_page[i] = '0;
         end
         expected_q.delete();
         fail_count <= 0;
         pending_count <= 0;
      end else begin
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected response frame %0d", $time, rsp_ch.frame_index);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.frame_index !== want.frame_index || rsp_ch.hit !== want.hit ||
                   rsp_ch.fetch_needed !== want.fetch_needed ||
                   rsp_ch.writeback_needed !== want.writeback_needed ||
                   rsp_ch.status !== want.status) begin
                  $display("%0t: mismatch expected f=%0d h=%0b fe=%0b wb=%0b st=%0d",
                           $time, want.frame_index, want.hit, want.fetch_needed,
                           want.writeback_needed, want.status);
                  $display("%0t:          actual   f=%0d h=%0b fe=%0b wb=%0b st=%0d",
                           $time, rsp_ch.frame_index, rsp_ch.hit, rsp_ch.fetch_needed,
                           rsp_ch.writeback_needed, rsp_ch.status);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (req_ch.valid && req_ch.ready)
            expected_q.push_back(pool_access(req_ch.opcode, req_ch.table_number,
                                             req_ch.page_number, req_ch.modified));
         pending_count <= expected_q.size();
      end
   end
endmodule

// File: tb/tb_top.sv
// stimulus and verdict for the page buffer pool frame table
// depends on lpbp_pkg, lpbp_if, lpbp_checker and the block itself
`timescale 1ns / 1ps

module tb_top;

   logic clock;
   logic reset;
   int   fail_count;
   int   pending_count;
   logic quiet_tx;
   logic quiet_rx;
   logic hold_rx;
   int   hold_cycles;

   lpbp_req_if req_ch ();
   lpbp_rsp_if rsp_ch ();

   lru_page_buffer_pool dut (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch));
   lpbp_checker chk (.clock(clock), .reset(reset), .req_ch(req_ch), .rsp_ch(rsp_ch),
                     .fail_count(fail_count), .pending_count(pending_count));

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #40ms;
      $display("Regression FAIL");
      $finish;
   end

   // receiver: random stalls, one long hold-off
   initial begin
      rsp_ch.ready = 1'b0;
      hold_cycles = 0;
      forever begin
         @(posedge clock);
         if (hold_rx && hold_cycles < 400) begin
            hold_cycles++;
            rsp_ch.ready <= 1'b0;
         end else rsp_ch.ready <= quiet_rx || ($urandom_range(99) >= 14);
      end
   end

   task automatic send_request(lpbp_pkg::opcode_type op, logic [3:0] tbl, logic [31:0] pg,
                               logic mod);
      req_ch.valid <= 1'b1;
      req_ch.opcode <= op;
      req_ch.table_number <= tbl;
      req_ch.page_number <= pg;
      req_ch.modified <= mod;
      do @(posedge clock); while (!req_ch.ready);
      if (!quiet_tx && $urandom_range(99) < 14) begin
         req_ch.valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   // pages from a small working set so hits and pinned-out cases are frequent
   task automatic random_request(int spread);
      logic [3:0]  tbl;
      logic [31:0] pg;
      tbl = 4'($urandom_range(spread % 4));
      pg = $urandom_range(spread);
      if ($urandom_range(15) == 0) begin
         tbl = 4'($urandom);
         pg = $urandom;
      end else if ($urandom_range(7) == 0) pg = pg ^ 32'hFFFF_FFF0;
      send_request(lpbp_pkg::opcode_type'($urandom_range(1)), tbl, pg,
                   1'($urandom_range(1)));
   endtask

   initial begin
      int guard;
      reset = 1'b1;
      quiet_tx = 1'b0;
      quiet_rx = 1'b0;
      hold_rx = 1'b0;
      req_ch.valid = 1'b0;
      req_ch.opcode = lpbp_pkg::OP_GET;
      req_ch.table_number = '0;
      req_ch.page_number = '0;
      req_ch.modified = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: extremes, put of absent page, pin all frames, put to zero dirty
      send_request(lpbp_pkg::OP_PUT, 4'hF, 32'hFFFF_FFFF, 1'b1);
      send_request(lpbp_pkg::OP_GET, 4'h0, 32'h0, 1'b0);
      send_request(lpbp_pkg::OP_GET, 4'h0, 32'h0, 1'b0);
      send_request(lpbp_pkg::OP_GET, 4'hF, 32'hFFFF_FFFF, 1'b1);
      for (int i = 2; i < 16; i++)
         send_request(lpbp_pkg::OP_GET, i[3:0], 32'hA5A5_0000 | i, 1'b0);
      send_request(lpbp_pkg::OP_GET, 4'h9, 32'h1234_5678, 1'b0);
      send_request(lpbp_pkg::OP_PUT, 4'hF, 32'hFFFF_FFFF, 1'b1);
      send_request(lpbp_pkg::OP_PUT, 4'hF, 32'hFFFF_FFFF, 1'b0);
      send_request(lpbp_pkg::OP_PUT, 4'h0, 32'h0, 1'b0);
      send_request(lpbp_pkg::OP_GET, 4'h9, 32'h1234_5678, 1'b0);
      // saturate a pin count
      for (int i = 0; i < 260; i++) send_request(lpbp_pkg::OP_GET, 4'h3, 32'hA5A5_0003, 1'b0);

      // random with a quiet stretch
      for (int n = 0; n < 870; n++) begin
         quiet_tx = (n >= 300 && n < 450);
         quiet_rx = quiet_tx;
         random_request(n < 600 ? 20 : 40);
         if (n == 700) hold_rx = 1'b1;
      end
      req_ch.valid <= 1'b0;
      @(posedge clock);

      guard = 0;
      while (pending_count != 0 && guard < 200000) begin
         @(posedge clock);
         guard++;
      end
      repeat (100) @(posedge clock);
      if (fail_count == 0 && pending_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule

// File: lru_page_buffer_pool.f
hw/rtl/lpbp_pkg.sv
hw/rtl/lpbp_if.sv
hw/rtl/lpbp_ram.sv
hw/rtl/lru_page_buffer_pool.sv
tb/lpbp_checker.sv
tb/tb_top.sv
